// File: rtl/i2cs_pkg.sv
// ----------------------------------------------------------------------------
// i2cs_pkg
// Shared types and constants of the I2C slave command register port.
// ----------------------------------------------------------------------------
package i2cs_pkg;

  // Item kinds on the input channel.
  localparam logic [1:0] KIND_BUS   = 2'd0;
  localparam logic [1:0] KIND_CURR  = 2'd1;
  localparam logic [1:0] KIND_VOLT  = 2'd2;
  localparam logic [1:0] KIND_VOLTB = 2'd3;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_SLAVE_ADDRESS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CURRENT_GAIN  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_VOLTAGE_GAIN  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_VOLTB_BOOST   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RELAY_FITTED  = 3'd4;

  // Register reset values.
  localparam logic [6:0] SLAVE_ADDRESS_RST = 7'd20;
  localparam logic [7:0] CURRENT_GAIN_RST  = 8'd27;
  localparam logic [7:0] VOLTAGE_GAIN_RST  = 8'd1;

  // Command bytes.
  localparam logic [7:0] CMD_FREEZE    = 8'h20;
  localparam logic [7:0] CMD_CURR_LO   = 8'h30;
  localparam logic [7:0] CMD_CURR_HI   = 8'h31;
  localparam logic [7:0] CMD_VOLT_LO   = 8'h40;
  localparam logic [7:0] CMD_VOLT_HI   = 8'h41;
  localparam logic [7:0] CMD_VOLTB_LO  = 8'h42;
  localparam logic [7:0] CMD_VOLTB_HI  = 8'h43;
  localparam logic [7:0] CMD_RELAY_OFF = 8'h50;
  localparam logic [7:0] CMD_RELAY_ON  = 8'h51;

  // Bits per byte on the bus.
  localparam logic [3:0] BYTE_BITS = 4'd8;

  // Bus phases.
  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_ADDR     = 3'd1,
    PH_ADDR_ACK = 3'd2,
    PH_DATA     = 3'd3,
    PH_DATA_ACK = 3'd4,
    PH_SEND     = 3'd5,
    PH_SEND_ACK = 3'd6
  } phase_t;

  // Payload of one input request.
  typedef struct packed {
    logic [1:0] kind;
    logic       scl;
    logic       sda;
    logic [9:0] sample;
  } item_t;

  // Payload of one result request.
  typedef struct packed {
    logic sda_pull_low;
    logic relay_on;
    logic in_transaction;
  } result_t;

endpackage

// File: rtl/i2cs_if.sv
// ----------------------------------------------------------------------------
// i2cs_item_if / i2cs_result_if
// Valid/ready channels carrying input items and result items.
// ----------------------------------------------------------------------------
interface i2cs_item_if;
  logic          valid;
  logic          ready;
  i2cs_pkg::item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface i2cs_result_if;
  logic            valid;
  logic            ready;
  i2cs_pkg::result_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// File: rtl/i2c_slave_command_register_port_top.sv
// ----------------------------------------------------------------------------
// i2c_slave_command_register_port_top
// Oversampling I2C slave with 7-bit addressing and a one-byte command set.
//
//   channel  | dir | payload                         | handshake
//   in_ch    | in  | kind, scl, sda, sample          | valid/ready
//   out_ch   | out | sda_pull_low, relay_on, in_trans| valid/ready
//   cfg      | in  | cfg_we, cfg_index, cfg_data     | write enable only
//
// Each accepted request updates the bus state in the same cycle and its result
// is held in the output register; one request per cycle is sustained while out_ch
// is ready, set by the single state update path (decode and the freeze multipliers).
// A request is taken if no result is held or the held one is taken that cycle.
// Synchronous active-high reset restores the register defaults and bus idle.
// ----------------------------------------------------------------------------
module i2c_slave_command_register_port_top (
  input  logic                              clk,
  input  logic                              rst,
  i2cs_item_if.sink                         in_ch,
  i2cs_result_if.source                     out_ch,
  input  logic                              cfg_we,
  input  logic [i2cs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [i2cs_pkg::CFG_DATA_W-1:0]   cfg_data
);

  // Configuration registers.
  logic [6:0] slave_address;
  logic [7:0] current_gain;
  logic [7:0] voltage_gain;
  logic       voltb_half_boost;
  logic       relay_fitted;

  // Bus and sample state.
  i2cs_pkg::phase_t phase, phase_next;
  logic [3:0]  bit_count, bit_count_next;
  logic [7:0]  shift_byte, shift_byte_next;
  logic        prev_scl, prev_scl_next;
  logic        prev_sda, prev_sda_next;
  logic [7:0]  response_byte, response_byte_next;
  logic        relay_level, relay_level_next;
  logic [9:0]  raw_curr, raw_curr_next;
  logic [9:0]  raw_volt, raw_volt_next;
  logic [9:0]  raw_voltb, raw_voltb_next;
  logic [15:0] frz_curr, frz_curr_next;
  logic [15:0] frz_volt, frz_volt_next;
  logic [15:0] frz_voltb, frz_voltb_next;

  // Output register.
  logic              out_valid;
  i2cs_pkg::result_t out_data;
  i2cs_pkg::result_t result_next;

  logic            accept;
  i2cs_pkg::item_t item;

  // Line events and freeze products.
  logic        start_cond, stop_cond, scl_rise, scl_fall;
  logic [17:0] curr_prod, volt_prod;
  logic [10:0] voltb_boost;

  assign item   = in_ch.payload;
  assign in_ch.ready = !out_valid || out_ch.ready;
  assign accept = in_ch.valid && in_ch.ready;

  assign out_ch.valid   = out_valid;
  assign out_ch.payload = out_data;

  // Configuration writes; indexes beyond the list are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      slave_address    <= i2cs_pkg::SLAVE_ADDRESS_RST;
      current_gain     <= i2cs_pkg::CURRENT_GAIN_RST;
      voltage_gain     <= i2cs_pkg::VOLTAGE_GAIN_RST;
      voltb_half_boost <= 1'b0;
      relay_fitted     <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        i2cs_pkg::REG_SLAVE_ADDRESS: slave_address    <= cfg_data[6:0];
        i2cs_pkg::REG_CURRENT_GAIN:  current_gain     <= cfg_data;
        i2cs_pkg::REG_VOLTAGE_GAIN:  voltage_gain     <= cfg_data;
        i2cs_pkg::REG_VOLTB_BOOST:   voltb_half_boost <= cfg_data[0];
        i2cs_pkg::REG_RELAY_FITTED:  relay_fitted     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Line conditions seen against the previous sample.
  assign start_cond = prev_scl && item.scl && prev_sda && !item.sda;
  assign stop_cond  = prev_scl && item.scl && !prev_sda && item.sda;
  assign scl_rise   = !prev_scl && item.scl;
  assign scl_fall   = prev_scl && !item.scl;

  // Freeze scaling of the raw samples.
  assign curr_prod   = raw_curr * current_gain;
  assign volt_prod   = raw_volt * voltage_gain;
  assign voltb_boost = {1'b0, raw_voltb} + {2'b00, raw_voltb[9:1]};

  // Next state of the bus engine and the sample store.
  always_comb begin
    phase_next         = phase;
    bit_count_next     = bit_count;
    shift_byte_next    = shift_byte;
    prev_scl_next      = prev_scl;
    prev_sda_next      = prev_sda;
    response_byte_next = response_byte;
    relay_level_next   = relay_level;
    raw_curr_next      = raw_curr;
    raw_volt_next      = raw_volt;
    raw_voltb_next     = raw_voltb;
    frz_curr_next      = frz_curr;
    frz_volt_next      = frz_volt;
    frz_voltb_next     = frz_voltb;

    case (item.kind)
      i2cs_pkg::KIND_BUS: begin
        prev_scl_next = item.scl;
        prev_sda_next = item.sda;
        if (start_cond) begin
          phase_next      = i2cs_pkg::PH_ADDR;
          bit_count_next  = 4'd0;
          shift_byte_next = 8'd0;
        end else if (stop_cond) begin
          phase_next = i2cs_pkg::PH_IDLE;
        end else if (scl_rise) begin
          // Shift in a bit while receiving an address or command byte.
          if ((phase == i2cs_pkg::PH_ADDR || phase == i2cs_pkg::PH_DATA) &&
              bit_count < i2cs_pkg::BYTE_BITS) begin
            shift_byte_next = {shift_byte[6:0], item.sda};
            bit_count_next  = bit_count + 4'd1;
          end
        end else if (scl_fall) begin
          case (phase)
            i2cs_pkg::PH_ADDR: begin
              if (bit_count >= i2cs_pkg::BYTE_BITS) begin
                if (shift_byte[7:1] == slave_address) begin
                  phase_next = i2cs_pkg::PH_ADDR_ACK;
                end else begin
                  phase_next = i2cs_pkg::PH_IDLE;
                end
              end
            end
            i2cs_pkg::PH_ADDR_ACK: begin
              bit_count_next = 4'd0;
              if (shift_byte[0]) begin
                shift_byte_next = response_byte;
                phase_next      = i2cs_pkg::PH_SEND;
              end else begin
                shift_byte_next = 8'd0;
                phase_next      = i2cs_pkg::PH_DATA;
              end
            end
            i2cs_pkg::PH_DATA: begin
              if (bit_count >= i2cs_pkg::BYTE_BITS) begin
                // Command decode; every command clears the response first.
                phase_next         = i2cs_pkg::PH_DATA_ACK;
                response_byte_next = 8'd0;
                case (shift_byte)
                  i2cs_pkg::CMD_RELAY_OFF: begin
                    if (relay_fitted) relay_level_next = 1'b0;
                  end
                  i2cs_pkg::CMD_RELAY_ON: begin
                    if (relay_fitted) relay_level_next = 1'b1;
                  end
                  i2cs_pkg::CMD_FREEZE: begin
                    frz_curr_next  = curr_prod[15:0];
                    frz_volt_next  = volt_prod[15:0];
                    frz_voltb_next = voltb_half_boost ? {5'd0, voltb_boost}
                                                      : {6'd0, raw_voltb};
                  end
                  i2cs_pkg::CMD_CURR_LO:  response_byte_next = frz_curr[7:0];
                  i2cs_pkg::CMD_CURR_HI:  response_byte_next = frz_curr[15:8];
                  i2cs_pkg::CMD_VOLT_LO:  response_byte_next = frz_volt[7:0];
                  i2cs_pkg::CMD_VOLT_HI:  response_byte_next = frz_volt[15:8];
                  i2cs_pkg::CMD_VOLTB_LO: response_byte_next = frz_voltb[7:0];
                  i2cs_pkg::CMD_VOLTB_HI: response_byte_next = frz_voltb[15:8];
                  default: ;
                endcase
              end
            end
            i2cs_pkg::PH_SEND: begin
              shift_byte_next = {shift_byte[6:0], 1'b0};
              bit_count_next  = bit_count + 4'd1;
              if (bit_count + 4'd1 >= i2cs_pkg::BYTE_BITS) begin
                phase_next = i2cs_pkg::PH_SEND_ACK;
              end
            end
            default: begin
              // Command ACK, master ACK slot and idle all end here.
              phase_next = i2cs_pkg::PH_IDLE;
            end
          endcase
        end
      end
      i2cs_pkg::KIND_CURR:  raw_curr_next  = item.sample;
      i2cs_pkg::KIND_VOLT:  raw_volt_next  = item.sample;
      default:              raw_voltb_next = item.sample;
    endcase
  end

  // Result from the state that this request leaves.
  always_comb begin
    result_next.sda_pull_low   = 1'b0;
    result_next.relay_on       = relay_level_next;
    result_next.in_transaction = (phase_next != i2cs_pkg::PH_IDLE);
    case (phase_next)
      i2cs_pkg::PH_ADDR_ACK: result_next.sda_pull_low = 1'b1;
      i2cs_pkg::PH_DATA_ACK: result_next.sda_pull_low = 1'b1;
      i2cs_pkg::PH_SEND:     result_next.sda_pull_low = !shift_byte_next[7];
      default: ;
    endcase
  end

  // State registers advance only on an accepted request.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= i2cs_pkg::PH_IDLE;
      bit_count     <= 4'd0;
      shift_byte    <= 8'd0;
      prev_scl      <= 1'b1;
      prev_sda      <= 1'b1;
      response_byte <= 8'd0;
      relay_level   <= 1'b0;
      raw_curr      <= 10'd0;
      raw_volt      <= 10'd0;
      raw_voltb     <= 10'd0;
      frz_curr      <= 16'd0;
      frz_volt      <= 16'd0;
      frz_voltb     <= 16'd0;
    end else if (accept) begin
      phase         <= phase_next;
      bit_count     <= bit_count_next;
      shift_byte    <= shift_byte_next;
      prev_scl      <= prev_scl_next;
      prev_sda      <= prev_sda_next;
      response_byte <= response_byte_next;
      relay_level   <= relay_level_next;
      raw_curr      <= raw_curr_next;
      raw_volt      <= raw_volt_next;
      raw_voltb     <= raw_voltb_next;
      frz_curr      <= frz_curr_next;
      frz_volt      <= frz_volt_next;
      frz_voltb     <= frz_voltb_next;
    end
  end

  // Output register: valid control is reset, the payload is not.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data <= result_next;
    end
  end

  // The held result reflects the state left by the last request.
  a_trans_matches_phase: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.in_transaction == (phase != i2cs_pkg::PH_IDLE)))
    else $error("held in_transaction disagrees with bus phase");

  a_relay_matches_level: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.relay_on == relay_level))
    else $error("held relay_on disagrees with relay level");

  // The bit counter never passes one byte.
  a_bit_count_range: assert property (@(posedge clk) disable iff (rst)
    bit_count <= i2cs_pkg::BYTE_BITS)
    else $error("bit counter beyond one byte");

  // Without a fitted relay the relay level never moves.
  a_relay_unfitted: assert property (@(posedge clk) disable iff (rst)
    (accept && !relay_fitted) |=> (relay_level == $past(relay_level)))
    else $error("relay changed while not fitted");

endmodule
